>>> rtl/lzw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzw_pkg;

  localparam int MAX_CODES  = 4096;
  localparam int FIRST_CODE = 256;
  localparam int SYM_W      = 8;
  localparam int OUT_CODE_W = 12;
  localparam int CODE_W     = $clog2(MAX_CODES);
  localparam int NF_W       = CODE_W + 1;
  localparam int DICT_DEPTH = MAX_CODES - FIRST_CODE;
  localparam int DICT_AW    = $clog2(DICT_DEPTH);
  localparam int HT_AW      = CODE_W + 1;
  localparam int HT_DEPTH   = 2 ** HT_AW;

  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [NF_W-1:0]       nf_t;
  typedef logic [SYM_W-1:0]      sym_t;
  typedef logic [HT_AW-1:0]      slot_t;
  typedef logic [DICT_AW-1:0]    dict_addr_t;
  typedef logic [OUT_CODE_W-1:0] out_code_t;

  typedef struct packed {
    code_t prefix;
    sym_t  sym;
    slot_t slot;
  } dict_entry_t;

  localparam int DICT_ENTRY_W = $bits(dict_entry_t);

  typedef struct packed {
    logic live;
    logic hit;
  } probe_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DICT_RD,
    ST_CHECK,
    ST_EMIT_MISS,
    ST_EMIT_EOB
  } state_e;

  function automatic slot_t hash_slot(code_t prefix, sym_t sym);
    return slot_t'(prefix) ^ (slot_t'(sym) << (HT_AW - SYM_W));
  endfunction

endpackage

`default_nettype wire

>>> rtl/lzw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lzw_probe.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot is live only if its code is allocated and that code points back here.
module lzw_probe (
  input  wire lzw_pkg::dict_entry_t entry_i,
  input  wire lzw_pkg::code_t       code_i,
  input  wire lzw_pkg::slot_t       slot_i,
  input  wire lzw_pkg::code_t       prefix_i,
  input  wire lzw_pkg::sym_t        sym_i,
  input  wire lzw_pkg::nf_t         next_free_i,
  output lzw_pkg::probe_t           probe_o
);

  logic in_range;
  logic live;

  assign in_range = (code_i >= lzw_pkg::code_t'(lzw_pkg::FIRST_CODE)) &&
                    (lzw_pkg::nf_t'(code_i) < next_free_i);
  assign live     = in_range && (entry_i.slot == slot_i);

  assign probe_o.live = live;
  assign probe_o.hit  = live && (entry_i.prefix == prefix_i) && (entry_i.sym == sym_i);

endmodule

`default_nettype wire

>>> rtl/lzw_encoder_core.sv
// Per byte: accepted in ST_IDLE, then each hash probe (linear probing, load
// factor below one half) passes ST_DICT_RD and ST_CHECK for the registered
// hash-table and dictionary reads. A miss adds ST_EMIT_MISS per emitted code,
// end of block adds ST_EMIT_EOB; both wait while the output is stalled. A block's
// first byte is only accepted (then ST_EMIT_EOB at end of block). After reset a
// clearing pass sweeps HT_DEPTH (8192) hash-table slots; no byte is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module lzw_encoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  symbol_i,
  input  wire logic        end_of_block_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [11:0]      code_o,
  output logic             last_code_o
);

  lzw_pkg::state_e     state_q, state_d;
  lzw_pkg::code_t      prefix_code_q, prefix_code_d;
  logic                prefix_valid_q, prefix_valid_d;
  lzw_pkg::nf_t        nf_q, nf_d;
  lzw_pkg::sym_t       sym_q, sym_d;
  logic                eob_q, eob_d;
  lzw_pkg::slot_t      slot_q, slot_d;
  lzw_pkg::code_t      probe_code_q, probe_code_d;
  lzw_pkg::code_t      emit_code_q, emit_code_d;
  logic                out_valid_q, out_valid_d;
  lzw_pkg::out_code_t  out_code_q, out_code_d;
  logic                out_last_q, out_last_d;
  lzw_pkg::slot_t      clr_cnt_q, clr_cnt_d;

  logic                 ht_we;
  lzw_pkg::slot_t       ht_waddr;
  lzw_pkg::code_t       ht_wdata;
  lzw_pkg::slot_t       ht_raddr;
  lzw_pkg::code_t       ht_rdata;
  logic                 dict_we;
  lzw_pkg::dict_addr_t  dict_waddr;
  lzw_pkg::dict_entry_t dict_wdata;
  lzw_pkg::dict_addr_t  dict_raddr;
  lzw_pkg::dict_entry_t dict_rdata;
  lzw_pkg::probe_t      probe;
  logic                 out_free;
  logic                 out_load;

  lzw_ram #(
    .WIDTH (lzw_pkg::CODE_W),
    .DEPTH (lzw_pkg::HT_DEPTH)
  ) u_hash_ram (
    .clk_i   (clk_i),
    .we_i    (ht_we),
    .waddr_i (ht_waddr),
    .wdata_i (ht_wdata),
    .raddr_i (ht_raddr),
    .rdata_o (ht_rdata)
  );

  lzw_ram #(
    .WIDTH (lzw_pkg::DICT_ENTRY_W),
    .DEPTH (lzw_pkg::DICT_DEPTH)
  ) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (dict_waddr),
    .wdata_i (dict_wdata),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  lzw_probe u_probe (
    .entry_i     (dict_rdata),
    .code_i      (probe_code_q),
    .slot_i      (slot_q),
    .prefix_i    (prefix_code_q),
    .sym_i       (sym_q),
    .next_free_i (nf_q),
    .probe_o     (probe)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign dict_raddr = lzw_pkg::dict_addr_t'(ht_rdata - lzw_pkg::code_t'(lzw_pkg::FIRST_CODE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= lzw_pkg::ST_CLEAR;
      prefix_code_q  <= '0;
      prefix_valid_q <= 1'b0;
      nf_q           <= lzw_pkg::nf_t'(lzw_pkg::FIRST_CODE);
      eob_q          <= 1'b0;
      out_valid_q    <= 1'b0;
      clr_cnt_q      <= '0;
    end else begin
      state_q        <= state_d;
      prefix_code_q  <= prefix_code_d;
      prefix_valid_q <= prefix_valid_d;
      nf_q           <= nf_d;
      eob_q          <= eob_d;
      out_valid_q    <= out_valid_d;
      clr_cnt_q      <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    slot_q       <= slot_d;
    probe_code_q <= probe_code_d;
    emit_code_q  <= emit_code_d;
    out_code_q   <= out_code_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d        = state_q;
    prefix_code_d  = prefix_code_q;
    prefix_valid_d = prefix_valid_q;
    nf_d           = nf_q;
    sym_d          = sym_q;
    eob_d          = eob_q;
    slot_d         = slot_q;
    probe_code_d   = probe_code_q;
    emit_code_d    = emit_code_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_code_d     = out_code_q;
    out_last_d     = out_last_q;
    clr_cnt_d      = clr_cnt_q;
    out_load       = 1'b0;
    ht_we          = 1'b0;
    ht_waddr       = slot_q;
    ht_wdata       = lzw_pkg::code_t'(nf_q);
    ht_raddr       = slot_q;
    dict_we        = 1'b0;
    dict_waddr     = lzw_pkg::dict_addr_t'(nf_q - lzw_pkg::nf_t'(lzw_pkg::FIRST_CODE));
    dict_wdata     = '{prefix: prefix_code_q, sym: sym_q, slot: slot_q};

    unique case (state_q)
      lzw_pkg::ST_CLEAR: begin
        ht_we     = 1'b1;
        ht_waddr  = clr_cnt_q;
        ht_wdata  = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == lzw_pkg::slot_t'(lzw_pkg::HT_DEPTH - 1)) begin
          state_d = lzw_pkg::ST_IDLE;
        end
      end
      lzw_pkg::ST_IDLE: begin
        ht_raddr = lzw_pkg::hash_slot(prefix_code_q, symbol_i);
        if (in_valid_i) begin
          sym_d = symbol_i;
          eob_d = end_of_block_i;
          if (!prefix_valid_q) begin
            prefix_code_d  = lzw_pkg::code_t'(symbol_i);
            prefix_valid_d = 1'b1;
            if (end_of_block_i) begin
              state_d = lzw_pkg::ST_EMIT_EOB;
            end
          end else begin
            slot_d  = lzw_pkg::hash_slot(prefix_code_q, symbol_i);
            state_d = lzw_pkg::ST_DICT_RD;
          end
        end
      end
      lzw_pkg::ST_DICT_RD: begin
        probe_code_d = ht_rdata;
        state_d      = lzw_pkg::ST_CHECK;
      end
      lzw_pkg::ST_CHECK: begin
        ht_raddr = slot_q + 1'b1;
        if (probe.hit) begin
          prefix_code_d = probe_code_q;
          state_d       = eob_q ? lzw_pkg::ST_EMIT_EOB : lzw_pkg::ST_IDLE;
        end else if (probe.live) begin
          slot_d  = slot_q + 1'b1;
          state_d = lzw_pkg::ST_DICT_RD;
        end else begin
          emit_code_d   = prefix_code_q;
          prefix_code_d = lzw_pkg::code_t'(sym_q);
          if (nf_q != lzw_pkg::nf_t'(lzw_pkg::MAX_CODES)) begin
            dict_we = 1'b1;
            ht_we   = 1'b1;
            nf_d    = nf_q + 1'b1;
          end
          state_d = lzw_pkg::ST_EMIT_MISS;
        end
      end
      lzw_pkg::ST_EMIT_MISS: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_code_d  = lzw_pkg::out_code_t'(emit_code_q);
          out_last_d  = 1'b0;
          state_d     = eob_q ? lzw_pkg::ST_EMIT_EOB : lzw_pkg::ST_IDLE;
        end
      end
      lzw_pkg::ST_EMIT_EOB: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_valid_d    = 1'b1;
          out_code_d     = lzw_pkg::out_code_t'(prefix_code_q);
          out_last_d     = 1'b1;
          nf_d           = lzw_pkg::nf_t'(lzw_pkg::FIRST_CODE);
          prefix_code_d  = '0;
          prefix_valid_d = 1'b0;
          state_d        = lzw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lzw_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != lzw_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign code_o      = out_code_q;
  assign last_code_o = out_last_q;

`ifndef SYNTHESIS
  a_nf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nf_q >= lzw_pkg::nf_t'(lzw_pkg::FIRST_CODE)) &&
    (nf_q <= lzw_pkg::nf_t'(lzw_pkg::MAX_CODES)))
    else $error("next free code out of range");

  a_prefix_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_valid_q |-> (lzw_pkg::nf_t'(prefix_code_q) < nf_q))
    else $error("prefix code not allocated");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lzw_pkg::ST_CLEAR) |-> (!out_valid_q && !prefix_valid_q))
    else $error("activity during clearing pass");

  a_eob_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=>
    (!prefix_valid_q && (nf_q == lzw_pkg::nf_t'(lzw_pkg::FIRST_CODE))))
    else $error("block state not cleared after last code");
`endif

endmodule

`default_nettype wire

>>> tb/sv/lzw_code_checker.sv
`timescale 1ns / 1ps

module lzw_code_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  symbol_i,
  input  logic        end_of_block_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [11:0] code_i,
  input  logic        last_code_i,
  input  logic        end_i,
  output int          errors_o,
  output int          pending_o,
  output int          bytes_o,
  output int          blocks_o,
  output int          codes_o,
  output logic        dict_filled_o
);

  typedef struct packed {
    lzw_pkg::out_code_t code;
    logic               last;
  } emitted_t;

  typedef logic [lzw_pkg::CODE_W+lzw_pkg::SYM_W-1:0] pair_key_t;

  emitted_t        expected_codes[$];
  lzw_pkg::code_t  pair_codes[pair_key_t];
  int              next_code;
  lzw_pkg::code_t  prefix;
  logic            prefix_live;
  logic            drained;
  logic            filled;
  int              errors;
  int              n_bytes;
  int              n_blocks;
  int              n_codes;

  initial begin
    errors_o      = 0;
    pending_o     = 0;
    bytes_o       = 0;
    blocks_o      = 0;
    codes_o       = 0;
    dict_filled_o = 1'b0;
    errors        = 0;
    n_bytes       = 0;
    n_blocks      = 0;
    n_codes       = 0;
    drained       = 1'b0;
    filled        = 1'b0;
  end

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("[%0t] MISMATCH %s: expected %0d got %0d", $time, what, exp_v, got_v);
    errors++;
  endtask

  task automatic push_code(input lzw_pkg::code_t c, input logic last);
    emitted_t e;
    e.code = lzw_pkg::out_code_t'(c);
    e.last = last;
    expected_codes.push_back(e);
  endtask

  task automatic encode_byte(input lzw_pkg::sym_t s, input logic eob);
    pair_key_t key;
    key = {prefix, s};
    if (!prefix_live) begin
      prefix      = lzw_pkg::code_t'(s);
      prefix_live = 1'b1;
    end else if (pair_codes.exists(key)) begin
      prefix = pair_codes[key];
    end else begin
      push_code(prefix, 1'b0);
      if (next_code < lzw_pkg::MAX_CODES) begin
        pair_codes[key] = lzw_pkg::code_t'(next_code);
        next_code++;
        if (next_code == lzw_pkg::MAX_CODES) filled = 1'b1;
      end
      prefix = lzw_pkg::code_t'(s);
    end
    if (eob) begin
      push_code(prefix, 1'b1);
      pair_codes.delete();
      next_code   = lzw_pkg::FIRST_CODE;
      prefix      = '0;
      prefix_live = 1'b0;
      n_blocks++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    emitted_t e;
    if (!rst_ni) begin
      expected_codes.delete();
      pair_codes.delete();
      next_code   = lzw_pkg::FIRST_CODE;
      prefix      = '0;
      prefix_live = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        n_bytes++;
        encode_byte(symbol_i, end_of_block_i);
      end
      if (out_valid_i && !out_stall_i) begin
        n_codes++;
        if (expected_codes.size() == 0) begin
          report("code with nothing pending", -1, code_i);
        end else begin
          e = expected_codes.pop_front();
          if (code_i !== e.code) report("code", e.code, code_i);
          if (last_code_i !== e.last) report("last_code", e.last, last_code_i);
        end
      end
      if (end_i && !drained) begin
        drained = 1'b1;
        if (expected_codes.size() != 0)
          report("codes never emitted", 0, expected_codes.size());
      end
    end
    errors_o      <= errors;
    pending_o     <= expected_codes.size();
    bytes_o       <= n_bytes;
    blocks_o      <= n_blocks;
    codes_o       <= n_codes;
    dict_filled_o <= filled;
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  symbol     = 8'd0;
  logic        eob        = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [11:0] code;
  logic        last_code;
  logic        calm       = 1'b0;
  logic        end_q      = 1'b0;

  int   errors;
  int   pending;
  int   n_bytes;
  int   n_blocks;
  int   n_codes;
  logic dict_filled;

  lzw_encoder_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .symbol_i       (symbol),
    .end_of_block_i (eob),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .code_o         (code),
    .last_code_o    (last_code)
  );

  lzw_code_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .symbol_i       (symbol),
    .end_of_block_i (eob),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .code_i         (code),
    .last_code_i    (last_code),
    .end_i          (end_q),
    .errors_o       (errors),
    .pending_o      (pending),
    .bytes_o        (n_bytes),
    .blocks_o       (n_blocks),
    .codes_o        (n_codes),
    .dict_filled_o  (dict_filled)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 37);
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_byte(input logic [7:0] s, input logic last);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= s;
    eob      <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender off until every pending code has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int         n;
    int         len;
    int         base;
    int         span;
    int         waited;
    logic       narrow;
    logic [7:0] s;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // single-byte blocks at both extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // alternating pair: prefix growth, ends on a miss
    for (int i = 0; i < 8; i++) send_byte(i[0] ? 8'h42 : 8'h41, i == 7);
    // run of one byte
    for (int i = 0; i < 6; i++) send_byte(8'h07, i == 5);
    // miss on the last byte: two codes
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_drained();

    // one long block of random bytes
    for (int i = 0; i < 200; i++) send_byte(8'($urandom_range(0, 255)), i == 199);
    wait_drained();

    n = 0;
    while (n < 220) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      narrow = ($urandom_range(0, 9) < 7);
      base   = $urandom_range(0, 255);
      span   = $urandom_range(1, 4);
      for (int k = 0; k < len; k++) begin
        calm <= (n >= 60 && n < 160);
        s = narrow ? 8'(base + $urandom_range(0, span - 1)) : 8'($urandom_range(0, 255));
        send_byte(s, k == len - 1);
        n++;
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
    end_q <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run covered %0d bytes in %0d blocks, %0d codes compared.",
             n_bytes, n_blocks, n_codes);
    $display("Dictionary reached capacity: %s", dict_filled ? "yes" : "no");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
